>>> hdl/slcp_pkg.sv
// Shared types and codes for the serial light command parser.
// No dependencies; compiled first.
package slcp_pkg;

    typedef logic [2:0] t_status;
    typedef logic [2:0] t_cmd;

    // status codes
    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_LIGHT    = 3'd1;
    localparam t_status ST_NOTALPHA = 3'd2;
    localparam t_status ST_UNKNOWN  = 3'd3;
    localparam t_status ST_EFFECT   = 3'd4;
    localparam t_status ST_INT1     = 3'd5;
    localparam t_status ST_INT2     = 3'd6;
    localparam t_status ST_HEX      = 3'd7;

    // command codes
    localparam t_cmd CMD_NONE   = 3'd0;
    localparam t_cmd CMD_CT     = 3'd1;
    localparam t_cmd CMD_RGB    = 3'd2;
    localparam t_cmd CMD_HSV    = 3'd3;
    localparam t_cmd CMD_BRIGHT = 3'd4;
    localparam t_cmd CMD_POWER  = 3'd5;
    localparam t_cmd CMD_TOGGLE = 3'd6;
    localparam t_cmd CMD_DFLT   = 3'd7;

    // byte constants
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_VT  = 8'h0b;
    localparam logic [7:0] CH_FF  = 8'h0c;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_SP  = 8'h20;

endpackage

>>> hdl/slcp_if.sv
// Valid/ready channel interfaces: received bytes in, parsed lines out.
// Depends on slcp_pkg.
interface slcp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slcp_out_if;
    logic               valid;
    logic               ready;
    slcp_pkg::t_status  status;
    logic [31:0]        light_number;
    slcp_pkg::t_cmd     command_code;
    logic [31:0]        first_value;
    logic [31:0]        second_value;
    logic               smooth_effect;

    modport source (output valid, output status, output light_number, output command_code,
                    output first_value, output second_value, output smooth_effect,
                    input ready);
    modport sink   (input valid, input status, input light_number, input command_code,
                    input first_value, input second_value, input smooth_effect,
                    output ready);
endinterface

>>> hdl/serial_light_command_parser_unit.sv
// Serial light command parser, top level.
// Depends on slcp_pkg and the channel interfaces in slcp_if.sv.
//
// Takes one received byte per beat and one beat per clock cycle; each byte is
// parsed by the field-phase logic in the cycle it is accepted. A line feed loads
// the result register, which presents the line's status and fields on the next
// cycle. Input ready drops only while a result sits in the result register, the
// output side is not taking it and the offered byte is a line feed; every other
// byte keeps flowing at one per cycle, since it produces no result. Lines longer
// than LINE_LIMIT bytes (CR and LF not counted) have their tail ignored; on any
// error every field but the status reads zero.
module serial_light_command_parser_unit #(
    parameter int LINE_LIMIT = 80
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slcp_in_if.sink     i_rx,
    slcp_out_if.source  o_res
);
    import slcp_pkg::*;

    localparam int CNT_W = $clog2(LINE_LIMIT + 1);
    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(LINE_LIMIT);

    typedef enum logic [2:0] {
        PH_LIGHT, PH_CMD, PH_EFFECT, PH_INT1, PH_HEX, PH_INT2, PH_DONE
    } t_phase;

    // line state
    logic [2:0]       r_phase_idx, n_phase_idx;
    t_cmd             r_cmd,       n_cmd;
    logic [31:0]      r_light,     n_light;
    logic [31:0]      r_val1,      n_val1;
    logic [31:0]      r_val2,      n_val2;
    logic             r_smooth,    n_smooth;
    t_status          r_err,       n_err;
    logic             r_halt,      n_halt;
    logic [CNT_W-1:0] r_cnt,       n_cnt;

    // result register
    logic             r_out_vld;
    t_status          r_o_status;
    logic [31:0]      r_o_light;
    t_cmd             r_o_cmd;
    logic [31:0]      r_o_val1;
    logic [31:0]      r_o_val2;
    logic             r_o_smooth;

    logic       accept;
    logic       is_lf;
    logic [7:0] c;
    t_phase     kind;

    assign c      = i_rx.rx_byte;
    // only a line feed needs the result register
    assign i_rx.ready = !r_out_vld || o_res.ready || !is_lf;
    assign accept = i_rx.valid && i_rx.ready;
    assign is_lf  = (c == CH_LF);

    always_comb begin
        case (r_cmd)
            CMD_NONE: kind = (r_phase_idx == 3'd0) ? PH_LIGHT :
                             (r_phase_idx == 3'd1) ? PH_CMD : PH_DONE;
            CMD_CT, CMD_BRIGHT, CMD_POWER:
                kind = (r_phase_idx == 3'd0) ? PH_EFFECT :
                       (r_phase_idx == 3'd1) ? PH_INT1 : PH_DONE;
            CMD_RGB:  kind = (r_phase_idx == 3'd0) ? PH_EFFECT :
                             (r_phase_idx == 3'd1) ? PH_HEX : PH_DONE;
            CMD_HSV:  kind = (r_phase_idx == 3'd0) ? PH_EFFECT :
                             (r_phase_idx == 3'd1) ? PH_INT1 :
                             (r_phase_idx == 3'd2) ? PH_INT2 : PH_DONE;
            CMD_TOGGLE: kind = (r_phase_idx == 3'd0) ? PH_EFFECT : PH_DONE;
            default:  kind = PH_DONE;
        endcase
    end

    always_comb begin
        logic       is_digit;
        logic       is_upper;
        logic       is_lower;
        logic       is_ws;
        logic [7:0] lc;
        logic [3:0] dec_d;
        logic [3:0] hex_d;

        is_digit = (c >= "0") && (c <= "9");
        is_upper = (c >= "A") && (c <= "Z");
        is_lower = (c >= "a") && (c <= "z");
        is_ws    = (c == CH_SP) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
        lc       = is_upper ? (c + 8'd32) : c;
        dec_d    = c[3:0];
        hex_d    = (lc >= "a") ? 4'(lc - "a" + 8'd10) : lc[3:0];

        n_phase_idx = r_phase_idx;
        n_cmd       = r_cmd;
        n_light     = r_light;
        n_val1      = r_val1;
        n_val2      = r_val2;
        n_smooth    = r_smooth;
        n_err       = r_err;
        n_halt      = r_halt;
        n_cnt       = r_cnt;

        if (c == CH_CR) begin
            // dropped, not counted
        end else if (is_lf) begin
            n_phase_idx = '0;
            n_cmd       = CMD_NONE;
            n_light     = '0;
            n_val1      = '0;
            n_val2      = '0;
            n_smooth    = 1'b0;
            n_err       = ST_OK;
            n_halt      = 1'b0;
            n_cnt       = '0;
        end else if (r_cnt < LIMIT) begin
            n_cnt = r_cnt + 1'b1;
            if (c != CH_NUL && !r_halt) begin
                if (is_ws) begin
                    if (kind != PH_DONE) n_phase_idx = r_phase_idx + 3'd1;
                end else begin
                    case (kind)
                        PH_LIGHT: begin
                            if (is_digit) n_light = (r_light << 3) + (r_light << 1)
                                                    + 32'(dec_d);
                            else begin n_err = ST_LIGHT; n_halt = 1'b1; end
                        end
                        PH_CMD: begin
                            if (!(is_upper || is_lower)) begin
                                n_err = ST_NOTALPHA; n_halt = 1'b1;
                            end else begin
                                n_phase_idx = '0;
                                case (c)
                                    "c":     n_cmd = CMD_CT;
                                    "r":     n_cmd = CMD_RGB;
                                    "h":     n_cmd = CMD_HSV;
                                    "b":     n_cmd = CMD_BRIGHT;
                                    "p":     n_cmd = CMD_POWER;
                                    "t":     n_cmd = CMD_TOGGLE;
                                    "d":     n_cmd = CMD_DFLT;
                                    default: begin
                                        n_phase_idx = r_phase_idx;
                                        n_err  = ST_UNKNOWN;
                                        n_halt = 1'b1;
                                    end
                                endcase
                            end
                        end
                        PH_EFFECT: begin
                            if (c == "s") n_smooth = 1'b1;
                            else if (c != "i") begin n_err = ST_EFFECT; n_halt = 1'b1; end
                        end
                        PH_INT1: begin
                            if (is_digit) n_val1 = (r_val1 << 3) + (r_val1 << 1)
                                                   + 32'(dec_d);
                            else begin n_err = ST_INT1; n_halt = 1'b1; end
                        end
                        PH_INT2: begin
                            if (is_digit) n_val2 = (r_val2 << 3) + (r_val2 << 1)
                                                   + 32'(dec_d);
                            else begin n_err = ST_INT2; n_halt = 1'b1; end
                        end
                        PH_HEX: begin
                            if ((lc >= "0" && lc <= "9") || (lc >= "a" && lc <= "f"))
                                n_val1 = {r_val1[27:0], hex_d};
                            else begin n_err = ST_HEX; n_halt = 1'b1; end
                        end
                        default: n_halt = 1'b1; // stray byte after the last field
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_idx <= '0;
            r_cmd       <= CMD_NONE;
            r_light     <= '0;
            r_val1      <= '0;
            r_val2      <= '0;
            r_smooth    <= 1'b0;
            r_err       <= ST_OK;
            r_halt      <= 1'b0;
            r_cnt       <= '0;
        end else if (accept) begin
            r_phase_idx <= n_phase_idx;
            r_cmd       <= n_cmd;
            r_light     <= n_light;
            r_val1      <= n_val1;
            r_val2      <= n_val2;
            r_smooth    <= n_smooth;
            r_err       <= n_err;
            r_halt      <= n_halt;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (accept && is_lf) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // payload needs no reset; fields zeroed when the line carried an error
    always_ff @(posedge i_clk) begin
        if (accept && is_lf) begin
            r_o_status <= r_err;
            r_o_light  <= (r_err == ST_OK) ? r_light  : '0;
            r_o_cmd    <= (r_err == ST_OK) ? r_cmd    : CMD_NONE;
            r_o_val1   <= (r_err == ST_OK) ? r_val1   : '0;
            r_o_val2   <= (r_err == ST_OK) ? r_val2   : '0;
            r_o_smooth <= (r_err == ST_OK) ? r_smooth : 1'b0;
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.status        = r_o_status;
    assign o_res.light_number  = r_o_light;
    assign o_res.command_code  = r_o_cmd;
    assign o_res.first_value   = r_o_val1;
    assign o_res.second_value  = r_o_val2;
    assign o_res.smooth_effect = r_o_smooth;

endmodule

>>> bench/tb_serial_light_command_parser_unit.sv
// Self-checking bench for serial_light_command_parser_unit: byte stream in, parsed lines out.
// Uses slcp_pkg and the channel interfaces of slcp_if.sv; a local parser model predicts lines.
`timescale 1ns / 100ps

module tb_serial_light_command_parser_unit;
    import slcp_pkg::*;

    localparam int LINE_MAX    = 80;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int RAND_BYTES  = 450;
    localparam string CMD_LETTERS = "crhbptd";

    typedef enum logic [2:0] {
        PK_LIGHT, PK_CMD, PK_EFFECT, PK_INT1, PK_HEX, PK_INT2, PK_DONE
    } t_field;

    typedef struct packed {
        t_status     status;
        logic [31:0] light;
        t_cmd        cmd;
        logic [31:0] first;
        logic [31:0] second;
        logic        smooth;
    } t_line;

    localparam t_line ZERO_LINE = '0;

    typedef struct {
        string      text;
        int         spot;    // extra bytes go in before text[spot]; -1 for none
        logic [7:0] extra;
        int         reps;
        bit         typed;
        t_line      want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    slcp_in_if  rx_ch ();
    slcp_out_if res_ch ();

    serial_light_command_parser_unit #(.LINE_LIMIT(LINE_MAX)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch)
    );

    // parser model state
    logic [2:0]  idx_q;
    t_cmd        cmd_q;
    logic [31:0] light_q;
    logic [31:0] v1_q;
    logic [31:0] v2_q;
    logic        smooth_q;
    t_status     err_q;
    logic        halted_q;
    logic [6:0]  count_q;

    t_line      lines_due[$];
    logic [7:0] line_bytes[$];
    t_dir_row   dir_rows[$];
    int         bad_lines = 0;
    int         idle_cycles = 0;
    int         rx_hold = 0;
    bit         tx_steady = 0;
    bit         rx_steady = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function void clear_line();
        idx_q    = '0;
        cmd_q    = CMD_NONE;
        light_q  = '0;
        v1_q     = '0;
        v2_q     = '0;
        smooth_q = 1'b0;
        err_q    = ST_OK;
        halted_q = 1'b0;
        count_q  = '0;
    endfunction

    function bit is_dec(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function void flag_error(input t_status code);
        err_q    = code;
        halted_q = 1'b1;
    endfunction

    function t_field cur_field();
        case (cmd_q)
            CMD_NONE:                     return idx_q == 0 ? PK_LIGHT :
                                                 (idx_q == 1 ? PK_CMD : PK_DONE);
            CMD_CT, CMD_BRIGHT, CMD_POWER: return idx_q == 0 ? PK_EFFECT :
                                                 (idx_q == 1 ? PK_INT1 : PK_DONE);
            CMD_RGB:                      return idx_q == 0 ? PK_EFFECT :
                                                 (idx_q == 1 ? PK_HEX : PK_DONE);
            CMD_HSV:                      return idx_q == 0 ? PK_EFFECT :
                                                 (idx_q == 1 ? PK_INT1 :
                                                 (idx_q == 2 ? PK_INT2 : PK_DONE));
            CMD_TOGGLE:                   return idx_q == 0 ? PK_EFFECT : PK_DONE;
            default:                      return PK_DONE;
        endcase
    endfunction

    // Advances the model by one byte; returns 1 with the parsed line on LF.
    function bit parse_rx_byte(input logic [7:0] c, output t_line res);
        t_field     f;
        t_cmd       hit;
        logic [7:0] lc;
        logic [3:0] nib;
        res = ZERO_LINE;
        if (c == CH_CR)
            return 1'b0;
        if (c == CH_LF) begin
            res.status = err_q;
            if (err_q == ST_OK) begin
                res.light  = light_q;
                res.cmd    = cmd_q;
                res.first  = v1_q;
                res.second = v2_q;
                res.smooth = smooth_q;
            end
            clear_line();
            return 1'b1;
        end
        if (count_q >= LINE_MAX)
            return 1'b0;
        count_q = count_q + 7'd1;
        if (c == CH_NUL || halted_q)
            return 1'b0;
        f = cur_field();
        if (c == CH_SP || c == CH_TAB || c == CH_VT || c == CH_FF) begin
            if (f != PK_DONE)
                idx_q = idx_q + 3'd1;
            return 1'b0;
        end
        case (f)
            PK_LIGHT: begin
                if (is_dec(c)) light_q = light_q * 32'd10 + 32'(c - "0");
                else flag_error(ST_LIGHT);
            end
            PK_CMD: begin
                case (c)
                    "c":     hit = CMD_CT;
                    "r":     hit = CMD_RGB;
                    "h":     hit = CMD_HSV;
                    "b":     hit = CMD_BRIGHT;
                    "p":     hit = CMD_POWER;
                    "t":     hit = CMD_TOGGLE;
                    "d":     hit = CMD_DFLT;
                    default: hit = CMD_NONE;
                endcase
                if (!((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")))
                    flag_error(ST_NOTALPHA);
                else if (hit == CMD_NONE)
                    flag_error(ST_UNKNOWN);
                else begin
                    cmd_q = hit;
                    idx_q = '0;
                end
            end
            PK_EFFECT: begin
                if (c == "s") smooth_q = 1'b1;
                else if (c != "i") flag_error(ST_EFFECT);
            end
            PK_INT1: begin
                if (is_dec(c)) v1_q = v1_q * 32'd10 + 32'(c - "0");
                else flag_error(ST_INT1);
            end
            PK_INT2: begin
                if (is_dec(c)) v2_q = v2_q * 32'd10 + 32'(c - "0");
                else flag_error(ST_INT2);
            end
            PK_HEX: begin
                lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
                if (is_dec(lc)) nib = 4'(lc - "0");
                else if (lc >= "a" && lc <= "f") nib = 4'(lc - "a" + 8'd10);
                else begin
                    flag_error(ST_HEX);
                    return 1'b0;
                end
                v1_q = {v1_q[27:0], 4'b0} + 32'(nib);
            end
            default: halted_q = 1'b1;   // anything past the last field ends the line quietly
        endcase
        return 1'b0;
    endfunction

    // Offers one beat, after a random gap unless tx_steady is set; the model advances when the beat is taken.
    task automatic send_byte(input logic [7:0] b, input bit typed, input t_line want);
        int    gap;
        t_line got;
        gap = tx_steady ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (!rx_ch.ready);
        if (parse_rx_byte(b, got))
            lines_due.push_back(typed ? want : got);
    endtask

    function void push_ws();
        case ($urandom_range(0, 7))
            0:       line_bytes.push_back(CH_TAB);
            1:       line_bytes.push_back(CH_VT);
            2:       line_bytes.push_back(CH_FF);
            default: line_bytes.push_back(CH_SP);
        endcase
    endfunction

    function void push_dec();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
        repeat (n) line_bytes.push_back(8'("0" + $urandom_range(0, 9)));
    endfunction

    function void push_hex();
        int d;
        repeat ($urandom_range(1, 9)) begin
            d = $urandom_range(0, 15);
            if (d < 10) line_bytes.push_back(8'("0" + d));
            else if ($urandom_range(0, 1)) line_bytes.push_back(8'("A" + d - 10));
            else line_bytes.push_back(8'("a" + d - 10));
        end
    endfunction

    // Mostly well-formed commands with random content; some noise, long or broken lines.
    function void build_line();
        int         form;
        logic [7:0] pick;
        line_bytes.delete();
        form = $urandom_range(0, 11);
        if (form == 0) begin
            repeat ($urandom_range(1, 12)) line_bytes.push_back(8'($urandom));
        end else if (form == 1) begin
            repeat ($urandom_range(70, 100)) begin
                case ($urandom_range(0, 3))
                    0:       line_bytes.push_back(8'("0" + $urandom_range(0, 9)));
                    1:       line_bytes.push_back(CH_SP);
                    2:       line_bytes.push_back(CH_NUL);
                    default: line_bytes.push_back(8'($urandom));
                endcase
            end
        end else begin
            push_dec();
            push_ws();
            if ($urandom_range(0, 19) == 0) pick = 8'("a" + $urandom_range(0, 25));
            else pick = CMD_LETTERS[$urandom_range(0, 6)];
            line_bytes.push_back(pick);
            line_bytes.push_back($urandom_range(0, 1) ? "s" : "i");
            case (pick)
                "c", "b", "p": begin push_ws(); push_dec(); end
                "r":           begin push_ws(); push_hex(); end
                "h":           begin push_ws(); push_dec(); push_ws(); push_dec(); end
                default: ;
            endcase
            if ($urandom_range(0, 3) == 0) push_ws();
            if ($urandom_range(0, 5) == 0)
                line_bytes.insert($urandom_range(0, line_bytes.size()), 8'($urandom));
            if ($urandom_range(0, 4) == 0) line_bytes.push_back(CH_CR);
        end
        line_bytes.push_back(CH_LF);
    endfunction

    // result side: random stalls, one long hold-off on request
    initial begin
        t_line due;
        int    gap;
        res_ch.ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                res_ch.ready <= 1'b0;
                repeat (rx_hold) @(posedge i_clk);
                rx_hold = 0;
            end
            if ($urandom_range(0, 7) == 0) rx_steady = !rx_steady;
            gap = rx_steady ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            if (lines_due.size() == 0) begin
                bad_lines++;
                if (bad_lines <= 10)
                    $display("%0t: result beat with nothing pending, status %0d",
                             $realtime, res_ch.status);
            end else begin
                due = lines_due.pop_front();
                if (res_ch.status !== due.status || res_ch.light_number !== due.light ||
                    res_ch.command_code !== due.cmd || res_ch.first_value !== due.first ||
                    res_ch.second_value !== due.second ||
                    res_ch.smooth_effect !== due.smooth) begin
                    bad_lines++;
                    if (bad_lines <= 10)
                        $display({"%0t: line mismatch exp/got: status %0d/%0d light %0h/%0h",
                                  " cmd %0d/%0d first %0h/%0h second %0h/%0h smooth %0b/%0b"},
                                 $realtime, due.status, res_ch.status,
                                 due.light, res_ch.light_number, due.cmd, res_ch.command_code,
                                 due.first, res_ch.first_value, due.second,
                                 res_ch.second_value, due.smooth, res_ch.smooth_effect);
                end
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        int sent;
        i_rst_n       <= 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        clear_line();
        dir_rows = '{
            '{"",                      -1, CH_NUL, 0, 1'b1, ZERO_LINE},
            '{"4294967295 hs 359 100", -1, CH_NUL, 0, 1'b1,
              '{ST_OK, 32'hFFFF_FFFF, CMD_HSV, 32'd359, 32'd100, 1'b1}},
            '{"4294967296 ci 4294967296", -1, CH_NUL, 0, 1'b0, ZERO_LINE},
            '{"12 ri ffFFff",          -1, CH_NUL, 0, 1'b1,
              '{ST_OK, 32'd12, CMD_RGB, 32'h00FF_FFFF, 32'd0, 1'b0}},
            '{"1 rs FFFFFFFFF",        -1, CH_NUL, 0, 1'b1,
              '{ST_OK, 32'd1, CMD_RGB, 32'hFFFF_FFFF, 32'd0, 1'b1}},
            '{"3 ci 6500",             -1, CH_NUL, 0, 1'b0, ZERO_LINE},
            '{"3 bs 100",              -1, CH_NUL, 0, 1'b0, ZERO_LINE},
            '{"3 ts",                  -1, CH_NUL, 0, 1'b0, ZERO_LINE},
            '{"3 d",                   -1, CH_NUL, 0, 1'b0, ZERO_LINE},
            '{"3\tci42",                4, CH_VT,  1, 1'b0, ZERO_LINE},
            '{"3 hi 12",                6, CH_FF,  1, 1'b0, ZERO_LINE},
            '{"x",                     -1, CH_NUL, 0, 1'b1,
              '{ST_LIGHT, 32'd0, CMD_NONE, 32'd0, 32'd0, 1'b0}},
            '{"5 1",                   -1, CH_NUL, 0, 1'b1,
              '{ST_NOTALPHA, 32'd0, CMD_NONE, 32'd0, 32'd0, 1'b0}},
            '{"5 q",                   -1, CH_NUL, 0, 1'b1,
              '{ST_UNKNOWN, 32'd0, CMD_NONE, 32'd0, 32'd0, 1'b0}},
            '{"5 C",                   -1, CH_NUL, 0, 1'b1,
              '{ST_UNKNOWN, 32'd0, CMD_NONE, 32'd0, 32'd0, 1'b0}},
            '{"5 cx 10",               -1, CH_NUL, 0, 1'b1,
              '{ST_EFFECT, 32'd0, CMD_NONE, 32'd0, 32'd0, 1'b0}},
            '{"5 ci 1a",               -1, CH_NUL, 0, 1'b1,
              '{ST_INT1, 32'd0, CMD_NONE, 32'd0, 32'd0, 1'b0}},
            '{"5 hi 1 2b",             -1, CH_NUL, 0, 1'b1,
              '{ST_INT2, 32'd0, CMD_NONE, 32'd0, 32'd0, 1'b0}},
            '{"5 ri 12G",              -1, CH_NUL, 0, 1'b1,
              '{ST_HEX, 32'd0, CMD_NONE, 32'd0, 32'd0, 1'b0}},
            '{"5 ri AbC9",             -1, CH_NUL, 0, 1'b0, ZERO_LINE},
            '{"5 ci 10 junk ?",        -1, CH_NUL, 0, 1'b0, ZERO_LINE},
            '{"1\r2 pi 3    \r",       -1, CH_NUL, 0, 1'b0, ZERO_LINE},
            '{"1 pi 5",                 1, CH_NUL, 1, 1'b0, ZERO_LINE},
            '{"1 ci 5",                 5, 8'hFF,  1, 1'b1,
              '{ST_INT1, 32'd0, CMD_NONE, 32'd0, 32'd0, 1'b0}},
            '{"7 ti ",                  5, 8'h80,  1, 1'b0, ZERO_LINE},
            // NULs count toward the line limit: the x is parsed after 79, dropped after 80
            '{"x",                      0, CH_NUL, 79, 1'b1,
              '{ST_LIGHT, 32'd0, CMD_NONE, 32'd0, 32'd0, 1'b0}},
            '{"x",                      0, CH_NUL, 80, 1'b1, ZERO_LINE}
        };
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            line_bytes.delete();
            for (int i = 0; i <= dir_rows[k].text.len(); i++) begin
                if (i == dir_rows[k].spot)
                    repeat (dir_rows[k].reps) line_bytes.push_back(dir_rows[k].extra);
                if (i < dir_rows[k].text.len())
                    line_bytes.push_back(dir_rows[k].text[i]);
            end
            line_bytes.push_back(CH_LF);
            tx_steady = $urandom_range(0, 1);
            foreach (line_bytes[i])
                send_byte(line_bytes[i], dir_rows[k].typed, dir_rows[k].want);
        end

        // drain completely before the stress part
        rx_ch.valid <= 1'b0;
        wait (lines_due.size() == 0);
        @(posedge i_clk);

        // long hold-off on the result side while line feeds keep coming
        rx_hold   = HOLD_CYCLES;
        tx_steady = 1'b1;
        repeat (8) send_byte(CH_LF, 1'b0, ZERO_LINE);

        sent = 0;
        while (sent < RAND_BYTES) begin
            build_line();
            tx_steady = ($urandom_range(0, 3) == 0);
            foreach (line_bytes[i]) send_byte(line_bytes[i], 1'b0, ZERO_LINE);
            sent += line_bytes.size();
        end
        rx_ch.valid <= 1'b0;

        wait (lines_due.size() == 0);
        repeat (10) @(posedge i_clk);
        if (bad_lines == 0 && lines_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
